// ----- rtl/eipc_pkg.sv -----
// ----------------------------------------------------------------------------
// Ethernet IP receive classifier package
// Shared beat types, class and destination codes, register map and sizes.
// ----------------------------------------------------------------------------
package eipc_pkg;

    // Frame word geometry.
    localparam int DATA_BYTES   = 8;
    localparam int DATA_W       = DATA_BYTES * 8;
    localparam int HOLD_DEPTH   = 3;
    localparam int ETH_HDR_BYTES = 14;

    // Frame position and length widths.
    localparam int INDEX_W   = 14;
    localparam int LEN_W     = 17;
    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    // Output queue sizing.
    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    // APB register map.
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_ARP_ETHERTYPE  = 2'd0;
    localparam logic [1:0] REG_IPV4_ETHERTYPE = 2'd1;
    localparam logic [1:0] REG_ICMP_PROTOCOL  = 2'd2;

    localparam logic [15:0] ARP_ETHERTYPE_RST  = 16'h0806;
    localparam logic [15:0] IPV4_ETHERTYPE_RST = 16'h0800;
    localparam logic [7:0]  ICMP_PROTOCOL_RST  = 8'h01;

    // Frame classes.
    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_ARP  = 2'd1;
    localparam logic [1:0] CLASS_ICMP = 2'd2;
    localparam logic [1:0] CLASS_IP   = 2'd3;

    // Output destinations.
    localparam logic [1:0] DEST_ARP  = 2'd0;
    localparam logic [1:0] DEST_ICMP = 2'd1;
    localparam logic [1:0] DEST_IP   = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0]     word_data;
        logic [DATA_BYTES-1:0] byte_strobe;
        logic                  frame_end;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]     out_data;
        logic [DATA_BYTES-1:0] out_strobe;
        logic                  out_end;
        logic [1:0]            destination;
    } out_item_t;

    // Results produced by one input beat, handed to the output queue.
    typedef struct packed {
        logic [1:0]                     count;
        out_item_t [MAX_RESULTS-1:0]    item;
    } push_t;

    typedef struct packed {
        logic [15:0] arp_ethertype;
        logic [15:0] ipv4_ethertype;
        logic [7:0]  icmp_protocol;
    } cfg_t;

endpackage

// ----- rtl/ethernet_ip_rx_classifier.sv -----
// ----------------------------------------------------------------------------
// Ethernet IP receive classifier
// Sorts received frame words into ARP, ICMP and other IPv4 paths.
// ----------------------------------------------------------------------------
// Frame words of 64 bits enter on the s_ channel, one beat per word, with
// frame_end marking the last word. Beats are passed on the m_ channel tagged
// with a destination: ARP frames pass whole, IPv4 frames pass up to their IP
// length with the strobe trimmed on the closing beat, other frames are dropped.
// The first two words of a frame are held until the type (word 1) and, for
// IPv4, the protocol and length (word 2) are known, then released in order.
// The registers on the APB port set the ARP and IPv4 ethertypes and the ICMP
// protocol number; write them only while no frame is in flight.
// A result beat passes the input register, then the output queue, to reach m_.
// One word is taken per cycle while the queue has room. The third word of an IPv4
// frame releases three beats; a four-entry queue drains one per cycle of m_ready.
// Reset empties the input register and output queue, clears the frame state
// and restores the register defaults. When the receiver stalls, the queue
// fills and s_ready drops as soon as a word's results would not fit.
// ----------------------------------------------------------------------------
module ethernet_ip_rx_classifier (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input word channel.
    input  logic                        s_valid,
    output logic                        s_ready,
    input  eipc_pkg::in_item_t          s_item,
    // Result channel.
    output logic                        m_valid,
    input  logic                        m_ready,
    output eipc_pkg::out_item_t         m_item,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [eipc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    eipc_pkg::cfg_t                    cfg_reg;
    eipc_pkg::push_t                   push;
    logic [eipc_pkg::CNT_W-1:0]        space;
    logic [1:0]                        reg_sel;
    logic                              cfg_write;

    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.arp_ethertype  <= eipc_pkg::ARP_ETHERTYPE_RST;
            cfg_reg.ipv4_ethertype <= eipc_pkg::IPV4_ETHERTYPE_RST;
            cfg_reg.icmp_protocol  <= eipc_pkg::ICMP_PROTOCOL_RST;
        end else if (cfg_write) begin
            case (reg_sel)
                eipc_pkg::REG_ARP_ETHERTYPE: begin
                    cfg_reg.arp_ethertype <= pwdata[15:0];
                end
                eipc_pkg::REG_IPV4_ETHERTYPE: begin
                    cfg_reg.ipv4_ethertype <= pwdata[15:0];
                end
                eipc_pkg::REG_ICMP_PROTOCOL: begin
                    cfg_reg.icmp_protocol <= pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_sel)
            eipc_pkg::REG_ARP_ETHERTYPE:  prdata = {16'h0, cfg_reg.arp_ethertype};
            eipc_pkg::REG_IPV4_ETHERTYPE: prdata = {16'h0, cfg_reg.ipv4_ethertype};
            eipc_pkg::REG_ICMP_PROTOCOL:  prdata = {24'h0, cfg_reg.icmp_protocol};
            default:                      prdata = 32'h0;
        endcase
    end

    eipc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .cfg     (cfg_reg),
        .space   (space),
        .push    (push)
    );

    eipc_obuf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .space   (space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// ----- rtl/eipc_core.sv -----
// ----------------------------------------------------------------------------
// Ethernet IP receive classifier core
// Registers the incoming beat, classifies it against the frame state and
// produces up to three result beats per input beat.
// ----------------------------------------------------------------------------
module eipc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  eipc_pkg::in_item_t   s_item,
    input  eipc_pkg::cfg_t       cfg,
    input  logic [eipc_pkg::CNT_W-1:0] space,
    output eipc_pkg::push_t      push
);

    typedef struct packed {
        logic [eipc_pkg::DATA_W-1:0]     data;
        logic [eipc_pkg::DATA_BYTES-1:0] strobe;
    } held_t;

    logic                              in_valid_reg;
    eipc_pkg::in_item_t                in_item_reg;
    logic [eipc_pkg::INDEX_W-1:0]      word_index_reg, word_index_next;
    logic [1:0]                        frame_class_reg, frame_class_next;
    logic [eipc_pkg::LEN_W-1:0]        frame_len_reg, frame_len_next;
    logic                              dropping_reg, dropping_next;
    held_t                             held0_reg, held1_reg;
    logic                              held0_we, held1_we;

    logic [1:0]                        n_new;
    eipc_pkg::out_item_t [eipc_pkg::MAX_RESULTS-1:0] res;
    logic                              fire;

    logic [eipc_pkg::DATA_W-1:0]       d;
    logic [eipc_pkg::DATA_BYTES-1:0]   s;
    logic                              e;
    logic [15:0]                       ethertype;
    logic [15:0]                       ip_len;
    logic [eipc_pkg::LEN_W-1:0]        pos;
    logic [eipc_pkg::LEN_W:0]          pos_end;
    logic [eipc_pkg::LEN_W-1:0]        remain;
    logic [eipc_pkg::DATA_BYTES-1:0]   trim_mask;
    logic [1:0]                        dest;
    logic [1:0]                        new_class;

    assign d = in_item_reg.word_data;
    assign s = in_item_reg.byte_strobe;
    assign e = in_item_reg.frame_end;

    // Header fields taken from the current beat.
    assign ethertype = {d[39:32], d[47:40]};
    assign ip_len    = {d[7:0], d[15:8]};
    assign new_class = (d[63:56] == cfg.icmp_protocol) ? eipc_pkg::CLASS_ICMP
                                                       : eipc_pkg::CLASS_IP;

    // Byte position of this beat and the bytes left in the IPv4 frame.
    assign pos     = eipc_pkg::LEN_W'(word_index_reg) *
                     eipc_pkg::LEN_W'(eipc_pkg::DATA_BYTES);
    assign pos_end = {1'b0, pos} + (eipc_pkg::LEN_W+1)'(eipc_pkg::DATA_BYTES);
    assign remain  = (frame_len_reg > pos) ? (frame_len_reg - pos) : '0;

    always_comb begin
        if (remain >= eipc_pkg::LEN_W'(eipc_pkg::DATA_BYTES)) begin
            trim_mask = '1;
        end else begin
            trim_mask = ~({eipc_pkg::DATA_BYTES{1'b1}} <<
                          remain[$clog2(eipc_pkg::DATA_BYTES)-1:0]);
        end
    end

    assign dest = (frame_class_reg == eipc_pkg::CLASS_ICMP) ? eipc_pkg::DEST_ICMP
                                                            : eipc_pkg::DEST_IP;

    // Classification and next frame state for the registered beat.
    always_comb begin
        word_index_next  = word_index_reg;
        frame_class_next = frame_class_reg;
        frame_len_next   = frame_len_reg;
        dropping_next    = dropping_reg;
        held0_we         = 1'b0;
        held1_we         = 1'b0;
        n_new            = 2'd0;
        res              = '0;

        if (dropping_reg) begin
            // Rest of a rejected or finished frame is discarded.
        end else if (word_index_reg == '0) begin
            held0_we = 1'b1;
        end else if (frame_class_reg == eipc_pkg::CLASS_ARP) begin
            n_new = 2'd1;
            res[0] = '{out_data: d, out_strobe: s, out_end: e,
                       destination: eipc_pkg::DEST_ARP};
        end else if (frame_class_reg != eipc_pkg::CLASS_NONE) begin
            n_new = 2'd1;
            if (pos_end >= {1'b0, frame_len_reg}) begin
                // Length reached: close the frame on this beat.
                res[0] = '{out_data: d, out_strobe: trim_mask, out_end: 1'b1,
                           destination: dest};
                dropping_next = 1'b1;
            end else begin
                res[0] = '{out_data: d, out_strobe: s, out_end: e,
                           destination: dest};
            end
        end else if (word_index_reg == eipc_pkg::INDEX_W'(1)) begin
            if (ethertype == cfg.arp_ethertype) begin
                frame_class_next = eipc_pkg::CLASS_ARP;
                n_new  = 2'd2;
                res[0] = '{out_data: held0_reg.data, out_strobe: held0_reg.strobe,
                           out_end: 1'b0, destination: eipc_pkg::DEST_ARP};
                res[1] = '{out_data: d, out_strobe: s, out_end: e,
                           destination: eipc_pkg::DEST_ARP};
            end else if (ethertype == cfg.ipv4_ethertype) begin
                held1_we = 1'b1;
            end else begin
                dropping_next = 1'b1;
            end
        end else begin
            // Third IPv4 beat: protocol and length decide, held beats drain.
            frame_len_next   = eipc_pkg::LEN_W'(ip_len) +
                               eipc_pkg::LEN_W'(eipc_pkg::ETH_HDR_BYTES);
            frame_class_next = new_class;
            n_new  = 2'd3;
            res[0] = '{out_data: held0_reg.data, out_strobe: held0_reg.strobe,
                       out_end: 1'b0,
                       destination: (new_class == eipc_pkg::CLASS_ICMP) ?
                                    eipc_pkg::DEST_ICMP : eipc_pkg::DEST_IP};
            res[1] = '{out_data: held1_reg.data, out_strobe: held1_reg.strobe,
                       out_end: 1'b0, destination: res[0].destination};
            res[2] = '{out_data: d, out_strobe: s, out_end: e,
                       destination: res[0].destination};
        end

        // Frame end clears the frame state, otherwise the index moves on.
        if (e) begin
            word_index_next  = '0;
            frame_class_next = eipc_pkg::CLASS_NONE;
            frame_len_next   = '0;
            dropping_next    = 1'b0;
        end else if (word_index_reg != eipc_pkg::INDEX_MAX) begin
            word_index_next = word_index_reg + eipc_pkg::INDEX_W'(1);
        end
    end

    // The beat moves on once the queue has room for all its results.
    assign fire    = in_valid_reg && ({{(eipc_pkg::CNT_W-2){1'b0}}, n_new} <= space);
    assign s_ready = !in_valid_reg || fire;

    assign push.count = fire ? n_new : 2'd0;
    assign push.item  = res;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Frame state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_index_reg  <= '0;
            frame_class_reg <= eipc_pkg::CLASS_NONE;
            frame_len_reg   <= '0;
            dropping_reg    <= 1'b0;
        end else if (fire) begin
            word_index_reg  <= word_index_next;
            frame_class_reg <= frame_class_next;
            frame_len_reg   <= frame_len_next;
            dropping_reg    <= dropping_next;
        end
    end

    // Held header beats of an IPv4 frame.
    always_ff @(posedge aclk) begin
        if (fire && held0_we) begin
            held0_reg <= '{data: d, strobe: s};
        end
        if (fire && held1_we) begin
            held1_reg <= '{data: d, strobe: s};
        end
    end

endmodule

// ----- rtl/eipc_obuf.sv -----
// ----------------------------------------------------------------------------
// Ethernet IP receive classifier output queue
// Small queue that takes up to three result beats at once and sends one beat
// per cycle on the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
module eipc_obuf (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  eipc_pkg::push_t            push,
    output logic [eipc_pkg::CNT_W-1:0] space,
    output logic                       m_valid,
    input  logic                       m_ready,
    output eipc_pkg::out_item_t        m_item
);

    eipc_pkg::out_item_t               fifo_mem [eipc_pkg::FIFO_DEPTH];
    logic [eipc_pkg::PTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [eipc_pkg::CNT_W-1:0]        count_reg;
    logic                              pop;

    assign m_valid = (count_reg != '0);
    assign m_item  = fifo_mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // Free entries, counting the one that leaves this cycle.
    assign space = eipc_pkg::CNT_W'(eipc_pkg::FIFO_DEPTH) - count_reg +
                   eipc_pkg::CNT_W'(pop);

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + eipc_pkg::PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + eipc_pkg::PTR_W'(pop);
            count_reg  <= count_reg + eipc_pkg::CNT_W'(push.count) -
                          eipc_pkg::CNT_W'(pop);
        end
    end

    // Entry writes, one per result of the pushing beat.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < eipc_pkg::MAX_RESULTS; k++) begin
            if (k < int'(push.count)) begin
                fifo_mem[wr_ptr_reg + eipc_pkg::PTR_W'(k)] <= push.item[k];
            end
        end
    end

endmodule

// ----- rtl/eipc_checker.sv -----
// ----------------------------------------------------------------------------
// Ethernet IP receive classifier port checker
// Watches the top level's ports for reset, destination, stall and register behavior.
// ----------------------------------------------------------------------------
module eipc_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  eipc_pkg::out_item_t         m_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [eipc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready
);

    // Reset empties the output queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat shown right after reset");

    // Only the three defined destinations are ever sent.
    a_dest_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.destination != 2'd3))
        else $error("undefined destination on a result beat");

    // A stalled result beat stays in place.
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("stalled result beat changed or vanished");

    // A written ARP ethertype reads back on the next cycle.
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready &&
         paddr[3:2] == eipc_pkg::REG_ARP_ETHERTYPE)
        |=> (paddr[3:2] != eipc_pkg::REG_ARP_ETHERTYPE ||
             prdata[15:0] == $past(pwdata[15:0])))
        else $error("ARP ethertype read-back mismatch");

endmodule

bind ethernet_ip_rx_classifier eipc_checker u_eipc_checker (.*);

// ----- bench/ethernet_ip_rx_classifier_test.sv -----
// ----------------------------------------------------------------------------
// Ethernet IP receive classifier testbench
// Feeds frame words through the classifier under several register settings
// and idle patterns, and checks every result beat against a predictor of the
// ethertype and protocol sorting, word holding and closing-beat trimming.
// ----------------------------------------------------------------------------
module ethernet_ip_rx_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT     = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BEATS  = 33;
    localparam int REPORT_MAX    = 10;
    localparam logic [15:0] OTHER_ETHERTYPE = 16'h86DD;
    localparam logic [7:0]  TCP_PROTOCOL    = 8'd6;

    typedef struct {
        eipc_pkg::in_item_t          beat;
        int                          typed_n;
        eipc_pkg::out_item_t [2:0]   typed;
    } dir_row_t;

    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    eipc_pkg::in_item_t              s_item  = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    eipc_pkg::out_item_t             m_item;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [eipc_pkg::ADDR_W-1:0]     paddr   = '0;
    logic [31:0]                     pwdata  = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    // Predictor copy of the registers and the frame state.
    logic [15:0]                     cfg_arp   = eipc_pkg::ARP_ETHERTYPE_RST;
    logic [15:0]                     cfg_ipv4  = eipc_pkg::IPV4_ETHERTYPE_RST;
    logic [7:0]                      cfg_icmp  = eipc_pkg::ICMP_PROTOCOL_RST;
    logic [eipc_pkg::INDEX_W-1:0]    word_pos  = '0;
    logic [1:0]                      frame_cls = eipc_pkg::CLASS_NONE;
    logic [eipc_pkg::LEN_W-1:0]      frame_len = '0;
    logic                            drop_rest = 1'b0;
    logic [eipc_pkg::DATA_W-1:0]     held_data [2];
    logic [eipc_pkg::DATA_BYTES-1:0] held_strb [2];

    eipc_pkg::out_item_t             expected_beats [$];
    eipc_pkg::out_item_t             fresh_beats [$];
    dir_row_t                        dir_rows [$];
    eipc_pkg::in_item_t              frame_q [$];
    int                              faults      = 0;
    int                              cycle_count = 0;
    int                              snd_idle    = 0;
    int                              rcv_stall   = 0;

    ethernet_ip_rx_classifier dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void report(string msg);
        faults++;
        if (faults <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endfunction

    function automatic eipc_pkg::out_item_t mk_beat(logic [eipc_pkg::DATA_W-1:0] d,
                                                    logic [eipc_pkg::DATA_BYTES-1:0] s,
                                                    logic e, logic [1:0] dest);
        eipc_pkg::out_item_t r;
        r.out_data    = d;
        r.out_strobe  = s;
        r.out_end     = e;
        r.destination = dest;
        return r;
    endfunction

    function automatic eipc_pkg::in_item_t frame_word(logic [eipc_pkg::DATA_W-1:0] d,
                                                      logic [eipc_pkg::DATA_BYTES-1:0] s,
                                                      logic e);
        eipc_pkg::in_item_t r;
        r.word_data   = d;
        r.byte_strobe = s;
        r.frame_end   = e;
        return r;
    endfunction

    // The ethertype travels high byte first in bytes 4 and 5 of word 1.
    function automatic logic [eipc_pkg::DATA_W-1:0] with_ethertype(
            logic [eipc_pkg::DATA_W-1:0] d, logic [15:0] etype);
        logic [eipc_pkg::DATA_W-1:0] r;
        r        = d;
        r[39:32] = etype[15:8];
        r[47:40] = etype[7:0];
        return r;
    endfunction

    // Word 2 carries the IP total length in bytes 0 and 1 and the protocol in byte 7.
    function automatic logic [eipc_pkg::DATA_W-1:0] with_ip_fields(
            logic [eipc_pkg::DATA_W-1:0] d, logic [7:0] proto, logic [15:0] iplen);
        logic [eipc_pkg::DATA_W-1:0] r;
        r        = d;
        r[63:56] = proto;
        r[7:0]   = iplen[15:8];
        r[15:8]  = iplen[7:0];
        return r;
    endfunction

    // Works out the result beats of one accepted word and advances the frame state.
    function automatic void classify_beat(eipc_pkg::in_item_t w);
        logic [15:0]                     etype;
        logic [15:0]                     iplen;
        logic [1:0]                      dest;
        int unsigned                     pos;
        int unsigned                     rem;
        logic [eipc_pkg::DATA_BYTES-1:0] mask;
        fresh_beats.delete();
        dest = (frame_cls == eipc_pkg::CLASS_ICMP) ? eipc_pkg::DEST_ICMP : eipc_pkg::DEST_IP;
        pos  = word_pos * eipc_pkg::DATA_BYTES;
        if (drop_rest) begin
            // The rest of a closed or unwanted frame is discarded.
        end else if (word_pos == 0) begin
            held_data[0] = w.word_data;
            held_strb[0] = w.byte_strobe;
        end else if (frame_cls == eipc_pkg::CLASS_ARP) begin
            fresh_beats.push_back(mk_beat(w.word_data, w.byte_strobe, w.frame_end,
                                          eipc_pkg::DEST_ARP));
        end else if (frame_cls != eipc_pkg::CLASS_NONE) begin
            // From word 3 on, the word that reaches the length closes the frame.
            if (pos + eipc_pkg::DATA_BYTES >= frame_len) begin
                rem  = (frame_len > pos) ? frame_len - pos : 0;
                mask = (rem >= eipc_pkg::DATA_BYTES) ? {eipc_pkg::DATA_BYTES{1'b1}}
                                                     : eipc_pkg::DATA_BYTES'((1 << rem) - 1);
                fresh_beats.push_back(mk_beat(w.word_data, mask, 1'b1, dest));
                drop_rest = 1'b1;
            end else begin
                fresh_beats.push_back(mk_beat(w.word_data, w.byte_strobe, w.frame_end, dest));
            end
        end else if (word_pos == 1) begin
            // ARP is checked first, so it wins when both ethertypes match.
            etype = {w.word_data[39:32], w.word_data[47:40]};
            if (etype == cfg_arp) begin
                frame_cls = eipc_pkg::CLASS_ARP;
                fresh_beats.push_back(mk_beat(held_data[0], held_strb[0], 1'b0,
                                              eipc_pkg::DEST_ARP));
                fresh_beats.push_back(mk_beat(w.word_data, w.byte_strobe, w.frame_end,
                                              eipc_pkg::DEST_ARP));
            end else if (etype == cfg_ipv4) begin
                held_data[1] = w.word_data;
                held_strb[1] = w.byte_strobe;
            end else if (!w.frame_end) begin
                drop_rest = 1'b1;
            end
        end else begin
            // Word 2 of an IPv4 frame decides the path and releases the held words.
            iplen     = {w.word_data[7:0], w.word_data[15:8]};
            frame_len = eipc_pkg::LEN_W'(iplen) + eipc_pkg::LEN_W'(eipc_pkg::ETH_HDR_BYTES);
            frame_cls = (w.word_data[63:56] == cfg_icmp) ? eipc_pkg::CLASS_ICMP
                                                         : eipc_pkg::CLASS_IP;
            dest      = (frame_cls == eipc_pkg::CLASS_ICMP) ? eipc_pkg::DEST_ICMP
                                                            : eipc_pkg::DEST_IP;
            fresh_beats.push_back(mk_beat(held_data[0], held_strb[0], 1'b0, dest));
            fresh_beats.push_back(mk_beat(held_data[1], held_strb[1], 1'b0, dest));
            fresh_beats.push_back(mk_beat(w.word_data, w.byte_strobe, w.frame_end, dest));
        end
        // Close the frame or move to the next word, saturating the position.
        if (w.frame_end) begin
            word_pos  = '0;
            frame_cls = eipc_pkg::CLASS_NONE;
            frame_len = '0;
            drop_rest = 1'b0;
        end else if (word_pos != eipc_pkg::INDEX_MAX) begin
            word_pos = word_pos + 1'b1;
        end
    endfunction

    function automatic void add_row(eipc_pkg::in_item_t b, int n,
                                    eipc_pkg::out_item_t [2:0] t);
        dir_row_t r;
        r.beat    = b;
        r.typed_n = n;
        r.typed   = t;
        dir_rows.push_back(r);
    endfunction

    // Directed words at the reset register values; a count of -1 means predicted.
    task automatic build_directed();
        eipc_pkg::in_item_t        w0;
        eipc_pkg::in_item_t        w1;
        eipc_pkg::out_item_t [2:0] none;
        eipc_pkg::out_item_t [2:0] typed;
        none = '0;
        // Single-word frames at the data and strobe extremes are dropped.
        add_row(frame_word('1, '1, 1'b1), 0, none);
        add_row(frame_word('0, '0, 1'b1), 0, none);
        // ARP frame closing at word 1: the held word passes first, without end.
        w0 = frame_word(64'h0123_4567_89AB_CDEF, '1, 1'b0);
        w1 = frame_word(with_ethertype(64'hFEDC_BA98_7654_3210,
                                       eipc_pkg::ARP_ETHERTYPE_RST), 8'h0F, 1'b1);
        typed    = none;
        typed[0] = mk_beat(w0.word_data, w0.byte_strobe, 1'b0, eipc_pkg::DEST_ARP);
        typed[1] = mk_beat(w1.word_data, w1.byte_strobe, 1'b1, eipc_pkg::DEST_ARP);
        add_row(w0, 0, none);
        add_row(w1, 2, typed);
        // IPv4 frame closing at word 1 never reaches its decision.
        add_row(frame_word({$urandom, $urandom}, '1, 1'b0), 0, none);
        add_row(frame_word(with_ethertype({$urandom, $urandom},
                                          eipc_pkg::IPV4_ETHERTYPE_RST), '1, 1'b1),
                0, none);
        // Unknown ethertype: every word of the frame is discarded.
        add_row(frame_word({$urandom, $urandom}, '1, 1'b0), 0, none);
        add_row(frame_word(with_ethertype({$urandom, $urandom}, OTHER_ETHERTYPE), '1, 1'b0),
                0, none);
        add_row(frame_word({$urandom, $urandom}, '1, 1'b1), 0, none);
        // Other IPv4 frame closing at word 2 keeps that word's own end.
        add_row(frame_word({$urandom, $urandom}, '1, 1'b0), -1, none);
        add_row(frame_word(with_ethertype({$urandom, $urandom},
                                          eipc_pkg::IPV4_ETHERTYPE_RST), '1, 1'b0),
                -1, none);
        add_row(frame_word(with_ip_fields({$urandom, $urandom}, TCP_PROTOCOL, 16'd100),
                           8'hF0, 1'b1), -1, none);
        // ICMP frame whose length is already passed at word 3 closes with no bytes.
        add_row(frame_word({$urandom, $urandom}, '1, 1'b0), -1, none);
        add_row(frame_word(with_ethertype({$urandom, $urandom},
                                          eipc_pkg::IPV4_ETHERTYPE_RST), '1, 1'b0),
                -1, none);
        add_row(frame_word(with_ip_fields({$urandom, $urandom},
                                          eipc_pkg::ICMP_PROTOCOL_RST, 16'd0),
                           '1, 1'b0), -1, none);
        add_row(frame_word({$urandom, $urandom}, '1, 1'b1), -1, none);
        // A 44-byte frame ends four bytes into word 5; word 6 is dropped.
        add_row(frame_word({$urandom, $urandom}, '1, 1'b0), -1, none);
        add_row(frame_word(with_ethertype({$urandom, $urandom},
                                          eipc_pkg::IPV4_ETHERTYPE_RST), '1, 1'b0),
                -1, none);
        add_row(frame_word(with_ip_fields({$urandom, $urandom}, TCP_PROTOCOL, 16'd30),
                           '1, 1'b0), -1, none);
        add_row(frame_word({$urandom, $urandom}, '1, 1'b0), -1, none);
        add_row(frame_word({$urandom, $urandom}, 8'h7E, 1'b0), -1, none);
        add_row(frame_word({$urandom, $urandom}, '1, 1'b0), -1, none);
        add_row(frame_word({$urandom, $urandom}, '1, 1'b1), -1, none);
        // IPv4 frame ending long before its maximal length keeps its own strobe.
        add_row(frame_word({$urandom, $urandom}, '1, 1'b0), -1, none);
        add_row(frame_word(with_ethertype({$urandom, $urandom},
                                          eipc_pkg::IPV4_ETHERTYPE_RST), '1, 1'b0),
                -1, none);
        add_row(frame_word(with_ip_fields({$urandom, $urandom},
                                          eipc_pkg::ICMP_PROTOCOL_RST, 16'hFFFF),
                           '1, 1'b0), -1, none);
        add_row(frame_word({$urandom, $urandom}, 8'h3C, 1'b1), -1, none);
    endtask

    // Offers one word, waits for its beat to be taken and records what it should produce.
    task automatic send_beat(input eipc_pkg::in_item_t w, input int typed_n,
                             input eipc_pkg::out_item_t [2:0] typed);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        classify_beat(w);
        if (typed_n < 0) begin
            foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
        end else begin
            for (int i = 0; i < typed_n; i++) expected_beats.push_back(typed[i]);
        end
    endtask

    // Holds the sender until every expected beat is out and the pipeline is quiet.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes one register, reads it back and updates the predictor copy.
    task automatic set_reg(logic [1:0] idx, logic [15:0] value);
        logic [31:0] got;
        logic [15:0] keep;
        keep = (idx == eipc_pkg::REG_ICMP_PROTOCOL) ? 16'h00FF : 16'hFFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= eipc_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= {16'h0000, value & keep};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        // Read back in a second transfer.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if ((got[15:0] & keep) !== (value & keep)) begin
            report($sformatf("register %0d read back %h, expected %h", idx, got[15:0] & keep,
                             value & keep));
        end
        case (idx)
            eipc_pkg::REG_ARP_ETHERTYPE: begin
                cfg_arp = value;
            end
            eipc_pkg::REG_IPV4_ETHERTYPE: begin
                cfg_ipv4 = value;
            end
            default: begin
                cfg_icmp = value[7:0];
            end
        endcase
    endtask

    task automatic set_config(logic [15:0] arp, logic [15:0] ipv4, logic [7:0] icmp);
        set_reg(eipc_pkg::REG_ARP_ETHERTYPE, arp);
        set_reg(eipc_pkg::REG_IPV4_ETHERTYPE, ipv4);
        set_reg(eipc_pkg::REG_ICMP_PROTOCOL, {8'h00, icmp});
    endtask

    // Builds one random frame: mostly well-formed ARP and IPv4, some other or broken.
    task automatic make_frame();
        int                              kind;
        int                              n_words;
        int                              need;
        int                              pick;
        bit                              ip_frame;
        logic [15:0]                     etype;
        logic [15:0]                     iplen;
        logic [7:0]                      proto;
        logic [eipc_pkg::DATA_W-1:0]     d;
        logic [eipc_pkg::DATA_BYTES-1:0] s;
        frame_q.delete();
        ip_frame = 1'b0;
        iplen    = '0;
        proto    = '0;
        kind     = $urandom_range(0, 99);
        if (kind < 25) begin
            etype   = cfg_arp;
            n_words = $urandom_range(1, 8);
        end else if (kind < 80) begin
            ip_frame = 1'b1;
            etype    = cfg_ipv4;
            proto    = ($urandom_range(0, 1) == 1) ? cfg_icmp : 8'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                iplen   = 16'($urandom);
                n_words = $urandom_range(1, 6);
            end else begin
                iplen = 16'($urandom_range(0, 80));
                need  = (int'(iplen) + eipc_pkg::ETH_HDR_BYTES + eipc_pkg::DATA_BYTES - 1) /
                        eipc_pkg::DATA_BYTES;
                if (need < 4) need = 4;
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    n_words = need;
                end else if (pick < 75) begin
                    n_words = $urandom_range(1, need);
                end else begin
                    n_words = need + $urandom_range(1, 3);
                end
            end
        end else begin
            etype   = 16'($urandom);
            n_words = $urandom_range(1, 5);
        end
        for (int i = 0; i < n_words; i++) begin
            d = {$urandom, $urandom};
            s = ($urandom_range(0, 3) == 0) ? 8'($urandom) : '1;
            if (i == 1) d = with_ethertype(d, etype);
            if (i == 2 && ip_frame) d = with_ip_fields(d, proto, iplen);
            frame_q.push_back(frame_word(d, s, i == n_words - 1));
        end
    endtask

    task automatic run_random(int beats);
        int sent;
        sent = 0;
        while (sent < beats) begin
            make_frame();
            foreach (frame_q[i]) send_beat(frame_q[i], -1, '0);
            sent += frame_q.size();
        end
    endtask

    // Receiver stalls at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= rcv_stall);
    end

    // Compare each delivered beat with the oldest expected one.
    always @(posedge aclk) begin
        eipc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                report($sformatf("unexpected beat: data %h strobe %h end %b dest %0d",
                                 m_item.out_data, m_item.out_strobe, m_item.out_end,
                                 m_item.destination));
            end else begin
                want = expected_beats.pop_front();
                if (m_item.out_data !== want.out_data || m_item.out_strobe !== want.out_strobe
                    || m_item.out_end !== want.out_end
                    || m_item.destination !== want.destination) begin
                    report($sformatf({"beat mismatch: expected data %h strobe %h end %b ",
                                      "dest %0d, got data %h strobe %h end %b dest %0d"},
                                     want.out_data, want.out_strobe, want.out_end,
                                     want.destination, m_item.out_data, m_item.out_strobe,
                                     m_item.out_end, m_item.destination));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        build_directed();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values, no idling: the directed words.
        foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed_n, dir_rows[i].typed);
        drain();

        // Low and high extremes of the registers, still with no idling.
        set_config(16'h0000, 16'hFFFF, 8'h00);
        run_random(RANDOM_BEATS);
        drain();

        // Opposite extremes with a mostly idle sender.
        snd_idle = 82;
        set_config(16'hFFFF, 16'h0000, 8'hFF);
        run_random(RANDOM_BEATS);
        drain();

        // Both ethertypes equal, so ARP must win; receiver mostly stalled.
        snd_idle  = 0;
        rcv_stall = 82;
        set_config(16'h88B5, 16'h88B5, 8'($urandom));
        run_random(RANDOM_BEATS);
        drain();

        // Defaults restored, light idling on both sides.
        snd_idle  = 22;
        rcv_stall = 22;
        set_config(eipc_pkg::ARP_ETHERTYPE_RST, eipc_pkg::IPV4_ETHERTYPE_RST,
                   eipc_pkg::ICMP_PROTOCOL_RST);
        run_random(RANDOM_BEATS);
        drain();

        if (faults == 0 && expected_beats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
